// File: rtl/pdt_pkg.sv
// Shared types, character codes and helpers for the pack directive tokenizer.
`default_nettype none

package pdt_pkg;

    localparam int BYTE_W      = 8;
    localparam int ENDIAN_W    = 2;
    localparam int TOK_COUNT_W = 31;

    // Output queue: one item may produce two tokens.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [ENDIAN_W-1:0] END_NONE   = 2'd0;
    localparam logic [ENDIAN_W-1:0] END_BIG    = 2'd1;
    localparam logic [ENDIAN_W-1:0] END_LITTLE = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_DIR  = 3'd1,
        PH_END1 = 3'd2,
        PH_NAT  = 3'd3,
        PH_END2 = 3'd4,
        PH_DIG  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]      directive;
        logic [ENDIAN_W-1:0]    endian;
        logic                   native;
        logic                   has_count;
        logic [TOK_COUNT_W-1:0] count;
        logic                   star;
        logic                   error;
        logic [BYTE_W-1:0]      error_mod;
        logic                   last;
    } token_t;

    function automatic logic is_skip(input logic [BYTE_W-1:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Directives that accept endianness and native-size modifiers.
    function automatic logic is_sized(input logic [BYTE_W-1:0] d);
        logic r;
        case (d)
            "s", "S", "i", "I", "l", "L", "q", "Q", "j", "J": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pack_directive_tokenizer_top.sv
// Pack format tokenizer: one format byte per item in, directive tokens out, up to two per byte.
// Each byte is held in the input register and parsed once the token queue has room; its
// tokens are written to the queue, whose head drives the outputs.
// Throughput: one byte per cycle; the four-entry token queue stalls the input only when
// it lacks room for two tokens, so a drained output sustains a byte every cycle.
// Reset clears the parser phase, comment flag, pending token and the queue pointers.
`default_nettype none

module pack_directive_tokenizer_top #(
    parameter int COUNT_BITS = 31
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [pdt_pkg::BYTE_W-1:0]     in_byte,
    input  wire logic                           in_last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [pdt_pkg::BYTE_W-1:0]          tok_directive,
    output logic [pdt_pkg::ENDIAN_W-1:0]        tok_endian,
    output logic                                tok_native,
    output logic                                tok_has_count,
    output logic [pdt_pkg::TOK_COUNT_W-1:0]     tok_count,
    output logic                                tok_star,
    output logic                                tok_error,
    output logic [pdt_pkg::BYTE_W-1:0]          tok_error_mod,
    output logic                                out_last
);
    import pdt_pkg::*;

    localparam int WIDE_W = COUNT_BITS + 4;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // Parser state.
    phase_t                phase_reg, phase_next, mid_phase;
    logic                  comment_reg, comment_next;
    logic [BYTE_W-1:0]     dir_reg, dir_next;
    logic [ENDIAN_W-1:0]   endian_reg, endian_next;
    logic                  native_reg, native_next;
    logic                  has_count_reg, has_count_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  error_reg, error_next;
    logic [BYTE_W-1:0]     error_mod_reg, error_mod_next;

    // Token queue.
    token_t             fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0]  fcnt_reg;

    logic proc_fire, pop, room;
    logic parse, is_end, is_nat, is_digit;
    logic act_start, act_end1, act_end2, act_nat, act_dig, act_star, act_break;
    logic [WIDE_W-1:0] count_wide;
    logic [3:0]        digit;
    logic              emit_a, emit_b;
    token_t            tok_a, tok_b, wr0, wr1;
    logic [1:0]        n_wr;
    token_t            head;

    assign room      = fcnt_reg <= FCNT_W'(FIFO_DEPTH - 2);
    assign proc_fire = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // Byte classification.
    assign is_end   = (byte_reg == CH_GT) || (byte_reg == CH_LT);
    assign is_nat   = (byte_reg == CH_UNDER) || (byte_reg == CH_BANG);
    assign is_digit = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign digit    = byte_reg[3:0];

    assign parse     = proc_fire && !comment_reg && (byte_reg != CH_HASH) && !is_skip(byte_reg);
    assign act_start = parse && (phase_reg == PH_IDLE);
    assign act_end1  = parse && (phase_reg == PH_DIR) && is_end;
    assign act_nat   = parse && (phase_reg == PH_DIR || phase_reg == PH_END1) && is_nat;
    assign act_end2  = parse && (phase_reg == PH_END1 || phase_reg == PH_NAT) && is_end;
    assign act_dig   = parse && (phase_reg != PH_IDLE) && is_digit;
    assign act_star  = parse && (phase_reg != PH_IDLE) && (byte_reg == CH_STAR);
    assign act_break = parse && (phase_reg != PH_IDLE)
                       && !(act_end1 || act_nat || act_end2 || act_dig || act_star);

    // count * 10 + digit; any bit above the count width means saturation.
    assign count_wide = (WIDE_W'(count_reg) << 3) + (WIDE_W'(count_reg) << 1) + WIDE_W'(digit);

    // Next state of the parser.
    always_comb
    begin
        mid_phase      = phase_reg;
        comment_next   = comment_reg;
        dir_next       = dir_reg;
        endian_next    = endian_reg;
        native_next    = native_reg;
        has_count_next = has_count_reg;
        count_next     = count_reg;
        error_next     = error_reg;
        error_mod_next = error_mod_reg;

        if (proc_fire)
        begin
            if (comment_reg)
            begin
                if (byte_reg == CH_NL)
                begin
                    comment_next = 1'b0;
                end
            end
            else if (byte_reg == CH_HASH)
            begin
                comment_next = 1'b1;
            end
        end

        if (act_start || act_break)
        begin
            mid_phase      = PH_DIR;
            dir_next       = byte_reg;
            endian_next    = END_NONE;
            native_next    = 1'b0;
            has_count_next = 1'b0;
            count_next     = '0;
            error_next     = 1'b0;
            error_mod_next = '0;
        end

        if ((act_end1 || act_end2 || act_nat) && !is_sized(dir_reg))
        begin
            error_next     = 1'b1;
            error_mod_next = byte_reg;
        end

        if (act_end1 || act_end2)
        begin
            endian_next = (byte_reg == CH_GT) ? END_BIG : END_LITTLE;
            mid_phase   = act_end1 ? PH_END1 : PH_END2;
        end

        if (act_nat)
        begin
            native_next = 1'b1;
            mid_phase   = PH_NAT;
        end

        if (act_dig)
        begin
            mid_phase = PH_DIG;
            if (phase_reg != PH_DIG)
            begin
                has_count_next = 1'b1;
                count_next     = COUNT_BITS'(digit);
            end
            else if (|count_wide[WIDE_W-1:COUNT_BITS])
            begin
                count_next = '1;
            end
            else
            begin
                count_next = count_wide[COUNT_BITS-1:0];
            end
        end

        if (act_star)
        begin
            mid_phase = PH_IDLE;
        end

        // The end of the string closes any open comment.
        if (proc_fire && last_reg)
        begin
            comment_next = 1'b0;
        end
    end

    assign phase_next = (proc_fire && last_reg) ? PH_IDLE : mid_phase;

    // Tokens: one ended by the byte, one closed by the end of the string.
    always_comb
    begin
        emit_a = act_star || act_break;
        emit_b = proc_fire && last_reg && (mid_phase != PH_IDLE);

        tok_a.directive = dir_reg;
        tok_a.endian    = endian_reg;
        tok_a.native    = native_reg;
        tok_a.has_count = has_count_reg;
        tok_a.count     = TOK_COUNT_W'(count_reg);
        tok_a.star      = act_star;
        tok_a.error     = error_reg;
        tok_a.error_mod = error_mod_reg;
        tok_a.last      = !emit_b;

        tok_b.directive = dir_next;
        tok_b.endian    = endian_next;
        tok_b.native    = native_next;
        tok_b.has_count = has_count_next;
        tok_b.count     = TOK_COUNT_W'(count_next);
        tok_b.star      = 1'b0;
        tok_b.error     = error_next;
        tok_b.error_mod = error_mod_next;
        tok_b.last      = 1'b1;

        wr0  = emit_a ? tok_a : tok_b;
        wr1  = tok_b;
        n_wr = {1'b0, emit_a} + {1'b0, emit_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            comment_reg   <= 1'b0;
            dir_reg       <= '0;
            endian_reg    <= END_NONE;
            native_reg    <= 1'b0;
            has_count_reg <= 1'b0;
            count_reg     <= '0;
            error_reg     <= 1'b0;
            error_mod_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            comment_reg   <= comment_next;
            dir_reg       <= dir_next;
            endian_reg    <= endian_next;
            native_reg    <= native_next;
            has_count_reg <= has_count_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
            error_mod_reg <= error_mod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= wr0;
        end
        if (n_wr == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_wr);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            fcnt_reg   <= fcnt_reg + FCNT_W'(n_wr) - FCNT_W'(pop);
        end
    end

    assign out_valid     = fcnt_reg != '0;
    assign head          = fifo_reg[rd_ptr_reg];
    assign tok_directive = head.directive;
    assign tok_endian    = head.endian;
    assign tok_native    = head.native;
    assign tok_has_count = head.has_count;
    assign tok_count     = head.count;
    assign tok_star      = head.star;
    assign tok_error     = head.error;
    assign tok_error_mod = head.error_mod;
    assign out_last      = head.last;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("token queue overfilled");

    a_room_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (n_wr != 2'd0) |-> (fcnt_reg <= FCNT_W'(FIFO_DEPTH - 2)))
        else $error("tokens written without room");

    a_end_of_string: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && last_reg) |=> (phase_reg == PH_IDLE && !comment_reg))
        else $error("parser not idle after end of string");

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(byte_reg)))
        else $error("held input byte lost");

    a_single_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (n_wr == 2'd1) |-> (wr0.last || !last_reg) && (wr0.last || emit_a))
        else $error("last flag missing on end of string token");
`endif

endmodule

`default_nettype wire

// File: verif/pack_directive_tokenizer_top_test.sv
// Self-checking testbench for the pack directive tokenizer: directed table, then random format strings.
`default_nettype none

module pack_directive_tokenizer_top_test;
    import pdt_pkg::*;

    localparam int COUNT_BITS = 31;
    localparam int RANDOM_BYTES = 1600;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              lst;
        bit                typed;
        token_t            want;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      in_byte;
    logic                   in_last;
    logic                   out_valid;
    logic                   out_stall;
    logic [BYTE_W-1:0]      tok_directive;
    logic [ENDIAN_W-1:0]    tok_endian;
    logic                   tok_native;
    logic                   tok_has_count;
    logic [TOK_COUNT_W-1:0] tok_count;
    logic                   tok_star;
    logic                   tok_error;
    logic [BYTE_W-1:0]      tok_error_mod;
    logic                   out_last;

    pack_directive_tokenizer_top #(.COUNT_BITS(COUNT_BITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .tok_directive(tok_directive),
        .tok_endian(tok_endian),
        .tok_native(tok_native),
        .tok_has_count(tok_has_count),
        .tok_count(tok_count),
        .tok_star(tok_star),
        .tok_error(tok_error),
        .tok_error_mod(tok_error_mod),
        .out_last(out_last)
    );

    // Tokenizer state as predicted by the testbench.
    phase_t            ph = PH_IDLE;
    logic              in_cmt = 1'b0;
    logic [BYTE_W-1:0] p_dir = '0;
    logic [1:0]        p_end = END_NONE;
    logic              p_nat = 1'b0;
    logic              p_hc = 1'b0;
    logic [63:0]       p_cnt = '0;
    logic              p_err = 1'b0;
    logic [BYTE_W-1:0] p_emod = '0;

    token_t            step_toks[$];
    token_t            tokens_due[$];
    logic [BYTE_W-1:0] fmt_bytes[$];
    row_t              plan[$];

    string sized_set = "sSiIlLqQjJ";
    string plain_set = "aAbBcCdDeEfFgGhHmMnNpPuUwxXZ@";

    int errors = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int tokens_checked = 0;
    int err_tokens = 0;
    int sat_tokens = 0;
    int quiet_cycles = 0;
    int src_calm = 0;
    int snk_calm = 0;

    function automatic logic blank_byte(input logic [BYTE_W-1:0] c);
        return (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic takes_width_mod(input logic [BYTE_W-1:0] d);
        logic r;
        case (d)
            "s", "S", "i", "I", "l", "L", "q", "Q", "j", "J": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic void open_token(input logic [BYTE_W-1:0] c);
        p_dir = c;
        p_end = END_NONE;
        p_nat = 1'b0;
        p_hc = 1'b0;
        p_cnt = '0;
        p_err = 1'b0;
        p_emod = '0;
        ph = PH_DIR;
    endfunction

    function automatic void close_token(input logic st);
        token_t t;
        t.directive = p_dir;
        t.endian = p_end;
        t.native = p_nat;
        t.has_count = p_hc;
        t.count = p_cnt[TOK_COUNT_W-1:0];
        t.star = st;
        t.error = p_err;
        t.error_mod = p_emod;
        t.last = 1'b0;
        step_toks.push_back(t);
        ph = PH_IDLE;
    endfunction

    function automatic void note_modifier(input logic [BYTE_W-1:0] c);
        if (!takes_width_mod(p_dir))
        begin
            p_err = 1'b1;
            p_emod = c;
        end
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] c);
        logic        is_end;
        logic [63:0] d;
        logic [63:0] mx;
        is_end = (c == CH_GT) || (c == CH_LT);
        mx = (64'd1 << COUNT_BITS) - 64'd1;
        if (ph == PH_IDLE)
            open_token(c);
        else if (ph <= PH_DIR && is_end)
        begin
            note_modifier(c);
            p_end = (c == CH_GT) ? END_BIG : END_LITTLE;
            ph = PH_END1;
        end
        else if (ph <= PH_END1 && (c == CH_UNDER || c == CH_BANG))
        begin
            note_modifier(c);
            p_nat = 1'b1;
            ph = PH_NAT;
        end
        else if (ph <= PH_NAT && is_end)
        begin
            note_modifier(c);
            p_end = (c == CH_GT) ? END_BIG : END_LITTLE;
            ph = PH_END2;
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = 64'(c - CH_ZERO);
            if (ph != PH_DIG)
            begin
                p_hc = 1'b1;
                p_cnt = d;
            end
            else if (p_cnt > (mx - d) / 64'd10)
                p_cnt = mx;
            else
                p_cnt = p_cnt * 64'd10 + d;
            ph = PH_DIG;
        end
        else if (c == CH_STAR)
            close_token(1'b1);
        else
        begin
            close_token(1'b0);
            open_token(c);
        end
    endfunction

    // Leaves in step_toks the tokens that one accepted byte produces.
    function automatic void tokenize_byte(input logic [BYTE_W-1:0] c, input logic lst);
        token_t t;
        step_toks.delete();
        if (in_cmt)
        begin
            if (c == CH_NL)
                in_cmt = 1'b0;
        end
        else if (c == CH_HASH)
            in_cmt = 1'b1;
        else if (!blank_byte(c))
            parse_byte(c);
        if (lst)
        begin
            if (ph != PH_IDLE)
                close_token(1'b0);
            in_cmt = 1'b0;
        end
        if (step_toks.size() > 0)
        begin
            t = step_toks.pop_back();
            t.last = 1'b1;
            step_toks.push_back(t);
        end
    endfunction

    // Idle cycles before the next item, with occasional runs of back-to-back items.
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic token_t want_tok(input logic [BYTE_W-1:0] dir, input logic [1:0] en,
                                        input logic nat, input logic hc,
                                        input logic [TOK_COUNT_W-1:0] cnt, input logic st,
                                        input logic er, input logic [BYTE_W-1:0] em);
        token_t t;
        t.directive = dir;
        t.endian = en;
        t.native = nat;
        t.has_count = hc;
        t.count = cnt;
        t.star = st;
        t.error = er;
        t.error_mod = em;
        t.last = 1'b1;
        return t;
    endfunction

    function automatic row_t row(input logic [BYTE_W-1:0] ch, input logic lst,
                                 input bit typed = 1'b0, input token_t want = '0);
        row_t r;
        r.ch = ch;
        r.lst = lst;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic void add_blank_maybe(input int pct);
        int v;
        if ($urandom_range(0, 99) < pct)
        begin
            v = $urandom_range(0, 6);
            fmt_bytes.push_back((v == 0) ? 8'd0 : (v == 6) ? 8'd32 : 8'(8 + v));
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_endian();
        return $urandom_range(0, 1) ? CH_GT : CH_LT;
    endfunction

    // Builds one random format string, mostly well-formed directives.
    function automatic void compose_format();
        int ntok;
        int r;
        int nd;
        fmt_bytes.delete();
        add_blank_maybe(10);
        ntok = $urandom_range(1, 6);
        repeat (ntok)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                fmt_bytes.push_back(CH_HASH);
                repeat ($urandom_range(0, 4)) fmt_bytes.push_back(8'($urandom_range(0, 255)));
                fmt_bytes.push_back(CH_NL);
                add_blank_maybe(50);
            end
            else if (r < 14)
                fmt_bytes.push_back(8'($urandom_range(0, 255)));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    fmt_bytes.push_back(sized_set[$urandom_range(0, sized_set.len() - 1)]);
                else if (r < 95)
                    fmt_bytes.push_back(plain_set[$urandom_range(0, plain_set.len() - 1)]);
                else
                    fmt_bytes.push_back(8'($urandom_range(0, 255)));
                add_blank_maybe(5);
                if ($urandom_range(0, 99) < 30)
                begin
                    fmt_bytes.push_back(pick_endian());
                    add_blank_maybe(5);
                end
                if ($urandom_range(0, 99) < 30)
                begin
                    fmt_bytes.push_back($urandom_range(0, 1) ? CH_UNDER : CH_BANG);
                    add_blank_maybe(5);
                end
                if ($urandom_range(0, 99) < 25)
                    fmt_bytes.push_back(pick_endian());
                // A modifier out of order starts a new token.
                if ($urandom_range(0, 99) < 5)
                    fmt_bytes.push_back($urandom_range(0, 1) ? pick_endian() : CH_BANG);
                if ($urandom_range(0, 99) < 40)
                begin
                    nd = ($urandom_range(0, 99) < 6) ? $urandom_range(10, 12)
                                                     : $urandom_range(1, 3);
                    repeat (nd)
                    begin
                        fmt_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        add_blank_maybe(2);
                    end
                end
                if ($urandom_range(0, 99) < 15)
                    fmt_bytes.push_back(CH_STAR);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic drive_item(input logic [BYTE_W-1:0] b, input logic lst,
                              input bit typed, input token_t want);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tokenize_byte(b, lst);
        if (typed)
            tokens_due.push_back(want);
        else
            foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
        bytes_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin : rx_side
        int k;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            k = draw_gap(snk_calm);
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : token_check
        token_t w;
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
                quiet_cycles = 0;
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (tokens_due.size() == 0)
                    report_mismatch("token with none expected, directive", tok_directive, 0);
                else
                begin
                    w = tokens_due.pop_front();
                    tokens_checked++;
                    if (w.error)
                        err_tokens++;
                    if (w.has_count && w.count == '1)
                        sat_tokens++;
                    if (tok_directive !== w.directive)
                        report_mismatch("tok_directive", tok_directive, w.directive);
                    if (tok_endian !== w.endian)
                        report_mismatch("tok_endian", tok_endian, w.endian);
                    if (tok_native !== w.native)
                        report_mismatch("tok_native", tok_native, w.native);
                    if (tok_has_count !== w.has_count)
                        report_mismatch("tok_has_count", tok_has_count, w.has_count);
                    if (tok_count !== w.count)
                        report_mismatch("tok_count", tok_count, w.count);
                    if (tok_star !== w.star)
                        report_mismatch("tok_star", tok_star, w.star);
                    if (tok_error !== w.error)
                        report_mismatch("tok_error", tok_error, w.error);
                    if (tok_error_mod !== w.error_mod)
                        report_mismatch("tok_error_mod", tok_error_mod, w.error_mod);
                    if (out_last !== w.last)
                        report_mismatch("out_last", out_last, w.last);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : main
        in_valid <= 1'b0;
        in_byte <= '0;
        in_last <= 1'b0;
        rst_n <= 1'b0;

        // Modifiers with whitespace inside the token; the last endianness wins.
        plan.push_back(row("s", 1'b0));
        plan.push_back(row(CH_GT, 1'b0));
        plan.push_back(row(CH_TAB, 1'b0));
        plan.push_back(row(CH_UNDER, 1'b0));
        plan.push_back(row(CH_LT, 1'b1, 1'b1,
                           want_tok("s", END_LITTLE, 1'b1, 1'b0, '0, 1'b0, 1'b0, '0)));
        // Ten nines overflow the count, which saturates.
        plan.push_back(row("C", 1'b0));
        for (int i = 0; i < 9; i++)
            plan.push_back(row(CH_NINE, 1'b0));
        plan.push_back(row(CH_NINE, 1'b1, 1'b1,
                           want_tok("C", END_NONE, 1'b0, 1'b1, '1, 1'b0, 1'b0, '0)));
        plan.push_back(row("J", 1'b0));
        plan.push_back(row(CH_STAR, 1'b1, 1'b1,
                           want_tok("J", END_NONE, 1'b0, 1'b0, '0, 1'b1, 1'b0, '0)));
        // Modifiers on an unsized directive, then a repeated one that becomes a directive
        // while the end of string closes it: two tokens from one byte.
        plan.push_back(row("n", 1'b0));
        plan.push_back(row(CH_LT, 1'b0));
        plan.push_back(row(CH_BANG, 1'b0));
        plan.push_back(row(CH_BANG, 1'b1));
        // Comment holding a NUL, then whitespace after its newline.
        plan.push_back(row(CH_HASH, 1'b0));
        plan.push_back(row(CH_NUL, 1'b0));
        plan.push_back(row(CH_NL, 1'b0));
        plan.push_back(row(CH_SPACE, 1'b0));
        plan.push_back(row(8'hFF, 1'b1, 1'b1,
                           want_tok(8'hFF, END_NONE, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            drive_item(plan[i].ch, plan[i].lst, plan[i].typed, plan[i].want);
        strings_sent = 5;

        while (bytes_sent < plan.size() + RANDOM_BYTES)
        begin
            compose_format();
            foreach (fmt_bytes[i])
                drive_item(fmt_bytes[i],
                           (i == fmt_bytes.size() - 1) || ($urandom_range(0, 99) < 3),
                           1'b0, '0);
            strings_sent++;
        end
        in_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Fed %0d format bytes in %0d strings and checked %0d tokens,",
                 bytes_sent, strings_sent, tokens_checked);
        $display("%0d of them with modifier errors and %0d with saturated counts.",
                 err_tokens, sat_tokens);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
